### rtl/dtd_pkg.sv
// Package with the word types, result codes and parser phases of the downlink TLV deframer.
`timescale 1ns / 1ps

package dtd_pkg;

  // Result kinds carried in the kind field of a result word.
  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_TRUNC   = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_t;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_LONGLEN = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4
  } phase_t;

  // Short length code that announces a separate length byte.
  localparam logic [3:0] LEN_ESCAPE = 4'hf;
  // Commands below this value have a handler.
  localparam logic [3:0] CMD_KNOWN_LIMIT = 4'd2;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
    logic [7:0] frame_length;
    logic [7:0] port;
  } in_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] command;
    logic       command_known;
    logic [5:0] record_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       record_last;
    logic       last_of_run;
  } out_word_t;

endpackage

### rtl/downlink_tlv_deframer_core.sv
// Top level of the downlink TLV deframer: byte parser and result queue.
`timescale 1ns / 1ps

// The deframer takes one frame byte per cycle on the in_ channel while in_stall
// is low and parses it in a single pass against its parser state registers.
// Each byte yields zero, one or two result words (a payload byte or empty-record
// marker followed by a frame-done marker when it is the last byte of the frame),
// which are written into a four-word result queue that feeds the out_ channel.
// The input side accepts a word whenever at least two queue slots are free, so
// the sustained rate is one byte per cycle while out_stall is low and each byte
// yields at most one result; a stalled output backs up into in_stall once the
// queue holds three or more words. A new frame_start byte aborts any frame in
// progress without a marker. The accepted port register is written through the
// cfg_ channel, which is always ready; write it only while the block is idle.

module downlink_tlv_deframer_core (
  input  logic              clk,
  input  logic              rst_n,
  // Input byte channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  dtd_pkg::in_word_t  in_data,
  // Result channel.
  output logic              out_valid,
  input  logic              out_stall,
  output dtd_pkg::out_word_t out_data,
  // Configuration write channel: the accepted port number.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  import dtd_pkg::*;

  // Configuration.
  logic [7:0] accepted_port_r;

  // Parser state.
  phase_t     phase_r, phase_nxt;
  logic [7:0] frame_left_r, frame_left_nxt;
  logic [5:0] pay_left_r, pay_left_nxt;
  logic [3:0] cmd_r, cmd_nxt;
  logic [5:0] len_r, len_nxt;
  logic [5:0] pos_r, pos_nxt;

  // Result queue.
  out_word_t        queue_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]  count_r, count_nxt;

  // Per-byte decode.
  logic       in_acc;
  logic       out_pop;
  logic       start;
  logic       port_miss;
  logic       flen_zero;
  logic [7:0] flen_m1;
  phase_t     eff_phase;
  logic [7:0] eff_left;
  logic [7:0] rem;
  logic       rem_zero;
  logic       is_long;
  logic [5:0] rec_len;
  logic [3:0] rec_cmd;
  logic       rec_over;
  logic       pay_last;

  // Results of the current byte.
  out_word_t  res0, res1;
  logic [1:0] res_cnt;

  function automatic out_word_t mk_word(kind_t k, logic [3:0] c, logic [5:0] l,
                                        logic [5:0] idx, logic [7:0] b, logic last);
    out_word_t w;
    w.kind          = k;
    w.command       = c;
    w.command_known = ((k == KIND_PAYLOAD) || (k == KIND_EMPTY)) && (c < CMD_KNOWN_LIMIT);
    w.record_length = l;
    w.byte_index    = idx;
    w.payload_byte  = b;
    w.record_last   = last;
    w.last_of_run   = 1'b0;
    return w;
  endfunction

  assign cfg_ready = 1'b1;
  assign out_valid = (count_r != '0);
  assign out_data  = queue_r[rd_ptr_r];
  assign out_pop   = out_valid && !out_stall;
  // Room for two results is needed before a byte can be taken.
  assign in_stall  = (count_r > Q_CW'(Q_DEPTH - 2));
  assign in_acc    = in_valid && !in_stall;

  assign start     = in_data.frame_start;
  assign port_miss = (in_data.port != accepted_port_r);
  assign flen_zero = (in_data.frame_length == 8'd0);
  assign flen_m1   = flen_zero ? 8'd0 : 8'(in_data.frame_length - 8'd1);

  // A start byte that opens a parsed frame is handled as a header byte.
  assign eff_phase = start ? PH_HEADER : phase_r;
  assign eff_left  = start ? in_data.frame_length : frame_left_r;
  assign rem       = (eff_left == 8'd0) ? 8'd0 : 8'(eff_left - 8'd1);
  assign rem_zero  = (rem == 8'd0);

  assign is_long   = (eff_phase == PH_HEADER) && (in_data.byte_value[3:0] == LEN_ESCAPE);
  assign rec_len   = (eff_phase == PH_HEADER) ? {2'b00, in_data.byte_value[3:0]}
                                              : in_data.byte_value[5:0];
  assign rec_cmd   = (eff_phase == PH_HEADER) ? in_data.byte_value[7:4] : cmd_r;
  assign rec_over  = ({2'b00, rec_len} > rem);
  assign pay_last  = (pay_left_r <= 6'd1);

  // Next parser state.
  always_comb begin
    phase_nxt      = phase_r;
    frame_left_nxt = frame_left_r;
    pay_left_nxt   = pay_left_r;
    cmd_nxt        = cmd_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    if (in_acc) begin
      if (start) begin
        pay_left_nxt = 6'd0;
        pos_nxt      = 6'd0;
        cmd_nxt      = 4'd0;
        len_nxt      = 6'd0;
      end
      if (start && port_miss) begin
        frame_left_nxt = flen_m1;
        phase_nxt      = (flen_m1 != 8'd0) ? PH_SKIP : PH_IDLE;
      end else if (start && flen_zero) begin
        frame_left_nxt = 8'd0;
        phase_nxt      = PH_IDLE;
      end else begin
        unique case (eff_phase)
          PH_IDLE: begin
          end
          PH_HEADER, PH_LONGLEN: begin
            if (eff_phase == PH_HEADER) begin
              cmd_nxt = in_data.byte_value[7:4];
            end
            frame_left_nxt = rem;
            if (is_long) begin
              phase_nxt = rem_zero ? PH_IDLE : PH_LONGLEN;
            end else if (rec_over) begin
              phase_nxt = rem_zero ? PH_IDLE : PH_SKIP;
            end else if (rec_len == 6'd0) begin
              phase_nxt = rem_zero ? PH_IDLE : PH_HEADER;
            end else begin
              len_nxt      = rec_len;
              pay_left_nxt = rec_len;
              pos_nxt      = 6'd0;
              phase_nxt    = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            frame_left_nxt = rem;
            pos_nxt        = 6'(pos_r + 6'd1);
            pay_left_nxt   = pay_last ? 6'd0 : 6'(pay_left_r - 6'd1);
            if (rem_zero) begin
              phase_nxt = PH_IDLE;
            end else if (pay_last) begin
              phase_nxt = PH_HEADER;
            end
          end
          PH_SKIP: begin
            frame_left_nxt = rem;
            if (rem_zero) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt      = PH_IDLE;
            frame_left_nxt = 8'd0;
          end
        endcase
      end
    end
  end

  // Result words of the current byte.
  always_comb begin
    out_word_t blank;
    blank   = mk_word(KIND_DONE, 4'd0, 6'd0, 6'd0, 8'd0, 1'b0);
    res0    = blank;
    res1    = blank;
    res_cnt = 2'd0;
    if (start && port_miss) begin
      res0    = mk_word(KIND_REJECT, 4'd0, 6'd0, 6'd0, 8'd0, 1'b0);
      res_cnt = 2'd1;
    end else if (start && flen_zero) begin
      res_cnt = 2'd1;
    end else begin
      unique case (eff_phase)
        PH_HEADER, PH_LONGLEN: begin
          if (is_long) begin
            if (rem_zero) begin
              res0    = mk_word(KIND_TRUNC, 4'd0, 6'd0, 6'd0, 8'd0, 1'b0);
              res_cnt = 2'd1;
            end
          end else if (rec_over) begin
            res0    = mk_word(KIND_TRUNC, 4'd0, 6'd0, 6'd0, 8'd0, 1'b0);
            res_cnt = 2'd1;
          end else if (rec_len == 6'd0) begin
            res0    = mk_word(KIND_EMPTY, rec_cmd, 6'd0, 6'd0, 8'd0, 1'b1);
            res_cnt = rem_zero ? 2'd2 : 2'd1;
          end
        end
        PH_PAYLOAD: begin
          res0    = mk_word(KIND_PAYLOAD, cmd_r, len_r, pos_r, in_data.byte_value, pay_last);
          res_cnt = rem_zero ? 2'd2 : 2'd1;
        end
        default: begin
        end
      endcase
    end
    if (res_cnt == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else begin
      res0.last_of_run = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      count_nxt = Q_CW'(count_nxt + Q_CW'(res_cnt));
    end
    if (out_pop) begin
      count_nxt = Q_CW'(count_nxt - Q_CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_port_r <= 8'd1;
      phase_r         <= PH_IDLE;
      frame_left_r    <= 8'd0;
      pay_left_r      <= 6'd0;
      cmd_r           <= 4'd0;
      len_r           <= 6'd0;
      pos_r           <= 6'd0;
      wr_ptr_r        <= '0;
      rd_ptr_r        <= '0;
      count_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        accepted_port_r <= cfg_data;
      end
      phase_r      <= phase_nxt;
      frame_left_r <= frame_left_nxt;
      pay_left_r   <= pay_left_nxt;
      cmd_r        <= cmd_nxt;
      len_r        <= len_nxt;
      pos_r        <= pos_nxt;
      if (in_acc) begin
        wr_ptr_r <= Q_AW'(wr_ptr_r + Q_AW'(res_cnt));
      end
      if (out_pop) begin
        rd_ptr_r <= Q_AW'(rd_ptr_r + Q_AW'(1));
      end
      count_r <= count_nxt;
    end
  end

  // Queue storage needs no reset; only written slots are ever read.
  always_ff @(posedge clk) begin
    if (in_acc && (res_cnt != 2'd0)) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (in_acc && (res_cnt == 2'd2)) begin
      queue_r[Q_AW'(wr_ptr_r + Q_AW'(1))] <= res1;
    end
  end

  // The queue never holds more words than it has slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("result queue overflow");

  // An idle parser has no frame bytes outstanding.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (frame_left_r == 8'd0))
    else $error("idle parser with frame bytes left");

  // A record being emitted always fits in the rest of its frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> ((pay_left_r != 6'd0) && ({2'b00, pay_left_r} <= frame_left_r)))
    else $error("payload record overruns its frame");

  // Frame-level markers always close the run of their input byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_data.kind == KIND_DONE) || (out_data.kind == KIND_TRUNC) ||
                   (out_data.kind == KIND_REJECT))) |-> out_data.last_of_run)
    else $error("frame marker not last of its run");

  // With no byte accepted and no word popped, the queue count stays unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && !out_pop) |=> (count_r == $past(count_r)))
    else $error("queue count changed without traffic");

endmodule
